@@ design/dmwbc_pkg.sv @@
// shared types, codes and default sizes for the direct-mapped write-back cache
// no dependencies; imported by every other design file of the block except dmwbc_checker
`default_nettype none

package dmwbc_pkg;

    localparam int unsigned DEF_INDEX_BITS       = 4;
    localparam int unsigned DEF_WORD_SELECT_BITS = 2;
    localparam int unsigned DEF_LINE_OFFSET_BITS = 4;
    localparam int unsigned DEF_ADDR_BITS        = 14;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 32;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LOAD  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // line status codes, code three is never written and reads as valid clean
    localparam logic [1:0] LS_INVALID = 2'd0;
    localparam logic [1:0] LS_CLEAN   = 2'd1;
    localparam logic [1:0] LS_DIRTY   = 2'd2;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic tag_rd;
        logic load_wr;
        logic decide;
        logic hit_rd;
        logic hit_wr;
        logic take_line;
        logic cnt_clr;
        logic wb_rd;
        logic fill_rd;
        logic tag_wr;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic hit;
        logic victim_dirty;
        logic cnt_done;
        logic clr_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ design/dmwbc_ifs.sv @@
// request and result channel interfaces with valid/ready handshake
// depends on dmwbc_pkg
`default_nettype none

interface dmwbc_req_if
    import dmwbc_pkg::*;
#(
    parameter int unsigned ADDR_BITS = DEF_ADDR_BITS
);
    logic                     valid;
    logic                     ready;
    logic [1:0]               operation;
    logic [ADDR_BITS-1:0]     address;
    logic signed [DATA_W-1:0] write_data;

    modport source (output valid, output operation, output address, output write_data,
                    input ready);
    modport sink   (input valid, input operation, input address, input write_data,
                    output ready);
endinterface

interface dmwbc_rsp_if
    import dmwbc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     was_hit;
    logic                     wrote_back;
    logic signed [DATA_W-1:0] read_data;
    logic [COUNT_W-1:0]       hit_count;
    logic [COUNT_W-1:0]       miss_count;
    logic [COUNT_W-1:0]       writeback_count;

    modport source (output valid, output was_hit, output wrote_back, output read_data,
                    output hit_count, output miss_count, output writeback_count,
                    input ready);
    modport sink   (input valid, input was_hit, input wrote_back, input read_data,
                    input hit_count, input miss_count, input writeback_count,
                    output ready);
endinterface

`default_nettype wire

@@ design/dmwbc_datapath.sv @@
// cache datapath: tag store, line store, backing store, counters, result register
// depends on dmwbc_pkg; driven by dmwbc_ctrl through t_dp_cmd
`default_nettype none

module dmwbc_datapath
    import dmwbc_pkg::*;
#(
    parameter int unsigned INDEX_BITS       = DEF_INDEX_BITS,
    parameter int unsigned WORD_SELECT_BITS = DEF_WORD_SELECT_BITS,
    parameter int unsigned LINE_OFFSET_BITS = DEF_LINE_OFFSET_BITS,
    parameter int unsigned ADDR_BITS        = DEF_ADDR_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_sts                       o_sts,
    input  wire logic [1:0]               i_operation,
    input  wire logic [ADDR_BITS-1:0]     i_address,
    input  wire logic signed [DATA_W-1:0] i_write_data,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic                          o_was_hit,
    output logic                          o_wrote_back,
    output logic signed [DATA_W-1:0]      o_read_data,
    output logic [COUNT_W-1:0]            o_hit_count,
    output logic [COUNT_W-1:0]            o_miss_count,
    output logic [COUNT_W-1:0]            o_writeback_count
);

    localparam int unsigned WS = (WORD_SELECT_BITS < LINE_OFFSET_BITS) ?
                                 WORD_SELECT_BITS : LINE_OFFSET_BITS;
    localparam int unsigned BS         = LINE_OFFSET_BITS - WS;
    localparam int unsigned LW         = 1 << WS;
    localparam int unsigned NUM_LINES  = 1 << INDEX_BITS;
    localparam int unsigned MA_W       = ADDR_BITS - BS;
    localparam int unsigned MEM_WORDS  = 1 << MA_W;
    localparam int unsigned TAG_SH     = LINE_OFFSET_BITS + INDEX_BITS;
    localparam int          TAG_RAW    = int'(ADDR_BITS) - int'(TAG_SH);
    localparam int unsigned TAG_W      = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int unsigned LINE_AW    = INDEX_BITS + WS;
    localparam int unsigned LINE_DEPTH = 1 << LINE_AW;
    localparam int unsigned WC_W       = WS + 1;
    localparam int unsigned CLR_W      = (MA_W > INDEX_BITS) ? MA_W : INDEX_BITS;
    localparam int unsigned VB_W       = TAG_W + TAG_SH;
    localparam int unsigned TE_W       = TAG_W + 2;

    // latched request
    t_op                      r_op;
    logic [ADDR_BITS-1:0]     r_addr;
    logic signed [DATA_W-1:0] r_wdata;

    // memories
    logic [TE_W-1:0]          r_tag_mem  [NUM_LINES];
    logic signed [DATA_W-1:0] r_line_mem [LINE_DEPTH];
    logic signed [DATA_W-1:0] r_back_mem [MEM_WORDS];
    logic [TE_W-1:0]          r_tag_rd;
    logic signed [DATA_W-1:0] r_line_rd;
    logic signed [DATA_W-1:0] r_mem_rd;

    // sequencing
    logic [CLR_W-1:0] r_clr_cnt;
    logic [WC_W-1:0]  r_cnt;
    logic [WC_W-1:0]  r_pcnt;
    logic             r_wb_pend;
    logic             r_fill_pend;

    // per-request results and running counts
    logic                     r_hit;
    logic                     r_wb;
    logic signed [DATA_W-1:0] r_rdata;
    logic [COUNT_W-1:0]       r_hits;
    logic [COUNT_W-1:0]       r_misses;
    logic [COUNT_W-1:0]       r_wbs;

    // result register
    logic                     r_out_valid;
    logic                     r_out_hit;
    logic                     r_out_wb;
    logic signed [DATA_W-1:0] r_out_rdata;
    logic [COUNT_W-1:0]       r_out_hits;
    logic [COUNT_W-1:0]       r_out_misses;
    logic [COUNT_W-1:0]       r_out_wbs;

    // address split
    logic [MA_W-1:0]       w_waddr;
    logic [MA_W-1:0]       w_base;
    logic [INDEX_BITS-1:0] w_idx;
    logic [TAG_W-1:0]      w_tag;
    logic [WC_W-1:0]       w_wsel;
    logic [LINE_AW-1:0]    w_line_base;
    logic [1:0]            w_line_st;
    logic [TAG_W-1:0]      w_line_tag;
    logic                  w_hit;
    logic                  w_dirty;
    logic [VB_W-1:0]       w_vbyte;
    logic [MA_W-1:0]       w_vbase;
    logic signed [DATA_W-1:0] w_fill_data;
    logic                  w_fill_sel;

    // memory port controls
    logic                     w_tag_we;
    logic [INDEX_BITS-1:0]    w_tag_waddr;
    logic [TE_W-1:0]          w_tag_wdata;
    logic                     w_line_we;
    logic [LINE_AW-1:0]       w_line_waddr;
    logic signed [DATA_W-1:0] w_line_wdata;
    logic                     w_line_re;
    logic [LINE_AW-1:0]       w_line_raddr;
    logic                     w_mem_we;
    logic [MA_W-1:0]          w_mem_waddr;
    logic signed [DATA_W-1:0] w_mem_wdata;
    logic [MA_W-1:0]          w_mem_raddr;

    always_comb begin
        w_waddr     = MA_W'(r_addr >> BS);
        w_base      = w_waddr & ~MA_W'(LW - 1);
        w_idx       = INDEX_BITS'(r_addr >> LINE_OFFSET_BITS);
        w_tag       = TAG_W'(r_addr >> TAG_SH);
        w_wsel      = WC_W'(w_waddr) & WC_W'(LW - 1);
        w_line_base = LINE_AW'(w_idx) << WS;
        w_line_st   = r_tag_rd[TE_W-1:TAG_W];
        w_line_tag  = r_tag_rd[TAG_W-1:0];
        w_hit       = (w_line_st != LS_INVALID) && (w_line_tag == w_tag);
        w_dirty     = (w_line_st == LS_DIRTY);
        w_vbyte     = (VB_W'(w_line_tag) << TAG_SH) | (VB_W'(w_idx) << LINE_OFFSET_BITS);
        w_vbase     = MA_W'(w_vbyte >> BS);
        w_fill_sel  = (r_pcnt == w_wsel);
        w_fill_data = ((r_op == OP_WRITE) && w_fill_sel) ? r_wdata : r_mem_rd;
    end

    always_comb begin
        o_sts.op           = r_op;
        o_sts.hit          = w_hit;
        o_sts.victim_dirty = w_dirty;
        o_sts.cnt_done     = (r_cnt == WC_W'(LW));
        o_sts.clr_done     = &r_clr_cnt;
        o_sts.out_free     = !r_out_valid || i_ready;
    end

    // tag store port
    always_comb begin
        w_tag_we    = 1'b0;
        w_tag_waddr = w_idx;
        w_tag_wdata = {LS_DIRTY, w_tag};
        if (i_cmd.clr_step) begin
            w_tag_we    = 1'b1;
            w_tag_waddr = INDEX_BITS'(r_clr_cnt);
            w_tag_wdata = '0;
        end else if (i_cmd.hit_wr) begin
            w_tag_we = 1'b1;
        end else if (i_cmd.tag_wr) begin
            w_tag_we    = 1'b1;
            w_tag_wdata = {(r_op == OP_WRITE) ? LS_DIRTY : LS_CLEAN, w_tag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tag_we) begin
            r_tag_mem[w_tag_waddr] <= w_tag_wdata;
        end
        if (i_cmd.tag_rd) begin
            r_tag_rd <= r_tag_mem[w_idx];
        end
    end

    // line store port
    always_comb begin
        w_line_we    = 1'b0;
        w_line_waddr = w_line_base | LINE_AW'(w_wsel);
        w_line_wdata = r_wdata;
        if (i_cmd.hit_wr) begin
            w_line_we = 1'b1;
        end else if (r_fill_pend) begin
            w_line_we    = 1'b1;
            w_line_waddr = w_line_base | LINE_AW'(r_pcnt);
            w_line_wdata = w_fill_data;
        end
        w_line_re    = i_cmd.hit_rd || i_cmd.wb_rd;
        w_line_raddr = i_cmd.hit_rd ? (w_line_base | LINE_AW'(w_wsel))
                                    : (w_line_base | LINE_AW'(r_cnt));
    end

    always_ff @(posedge i_clk) begin
        if (w_line_we) begin
            r_line_mem[w_line_waddr] <= w_line_wdata;
        end
        if (w_line_re) begin
            r_line_rd <= r_line_mem[w_line_raddr];
        end
    end

    // backing store port
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = w_waddr;
        w_mem_wdata = r_wdata;
        if (i_cmd.clr_step) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = MA_W'(r_clr_cnt);
            w_mem_wdata = '0;
        end else if (i_cmd.load_wr) begin
            w_mem_we = 1'b1;
        end else if (r_wb_pend) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = w_vbase + MA_W'(r_pcnt);
            w_mem_wdata = r_line_rd;
        end
        w_mem_raddr = w_base + MA_W'(r_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_back_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (i_cmd.fill_rd) begin
            r_mem_rd <= r_back_mem[w_mem_raddr];
        end
    end

    // request registers and line word counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_op'(i_operation);
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
        if (i_cmd.decide || i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.wb_rd || i_cmd.fill_rd) begin
            r_cnt <= r_cnt + WC_W'(1);
        end
        if (i_cmd.wb_rd || i_cmd.fill_rd) begin
            r_pcnt <= r_cnt;
        end
        if (i_cmd.capture) begin
            r_hit   <= 1'b0;
            r_wb    <= 1'b0;
            r_rdata <= '0;
        end else begin
            if (i_cmd.decide) begin
                r_hit <= w_hit;
                r_wb  <= !w_hit && w_dirty;
            end
            if (i_cmd.load_wr || i_cmd.hit_wr) begin
                r_rdata <= r_wdata;
            end else if (i_cmd.take_line) begin
                r_rdata <= r_line_rd;
            end else if (r_fill_pend && w_fill_sel) begin
                r_rdata <= w_fill_data;
            end
        end
        if (i_cmd.out_load) begin
            r_out_hit    <= r_hit;
            r_out_wb     <= r_wb;
            r_out_rdata  <= r_rdata;
            r_out_hits   <= r_hits;
            r_out_misses <= r_misses;
            r_out_wbs    <= r_wbs;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_wb_pend   <= 1'b0;
            r_fill_pend <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_wbs       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + CLR_W'(1);
            end
            r_wb_pend   <= i_cmd.wb_rd;
            r_fill_pend <= i_cmd.fill_rd;
            if (i_cmd.decide) begin
                if (w_hit) begin
                    r_hits <= r_hits + COUNT_W'(1);
                end else begin
                    r_misses <= r_misses + COUNT_W'(1);
                    if (w_dirty) begin
                        r_wbs <= r_wbs + COUNT_W'(1);
                    end
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_was_hit         = r_out_hit;
    assign o_wrote_back      = r_out_wb;
    assign o_read_data       = r_out_rdata;
    assign o_hit_count       = r_out_hits;
    assign o_miss_count      = r_out_misses;
    assign o_writeback_count = r_out_wbs;

endmodule

`default_nettype wire

@@ design/dmwbc_ctrl.sv @@
// cache controller state machine: clear sweep, lookup, write-back, fill, respond
// depends on dmwbc_pkg; commands dmwbc_datapath
`default_nettype none

module dmwbc_ctrl
    import dmwbc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_req_valid,
    output logic         o_req_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_LOOKUP,
        S_HIT_DATA,
        S_WB,
        S_FILL,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.op) inside
                    OP_READ, OP_WRITE: begin
                        o_cmd.tag_rd = 1'b1;
                        n_state      = S_LOOKUP;
                    end
                    OP_LOAD: begin
                        o_cmd.load_wr = 1'b1;
                        n_state       = S_RESP;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_LOOKUP: begin
                o_cmd.decide = 1'b1;
                if (i_sts.hit) begin
                    if (i_sts.op == OP_WRITE) begin
                        o_cmd.hit_wr = 1'b1;
                        n_state      = S_RESP;
                    end else begin
                        o_cmd.hit_rd = 1'b1;
                        n_state      = S_HIT_DATA;
                    end
                end else if (i_sts.victim_dirty) begin
                    n_state = S_WB;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_HIT_DATA: begin
                o_cmd.take_line = 1'b1;
                n_state         = S_RESP;
            end
            S_WB: begin
                if (!i_sts.cnt_done) begin
                    o_cmd.wb_rd = 1'b1;
                end else begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_FILL;
                end
            end
            S_FILL: begin
                if (!i_sts.cnt_done) begin
                    o_cmd.fill_rd = 1'b1;
                end else begin
                    o_cmd.tag_wr = 1'b1;
                    n_state      = S_RESP;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ design/direct_mapped_write_back_cache_core.sv @@
// request handling (LW = words per line, 4 by default): a load or unused op goes straight to
//   the result; a hit reads or writes the line; a miss first writes a dirty victim's LW words back,
//   then fills the line's LW words from the backing store, one word a cycle
// one request at a time; next request is taken the cycle after the result is registered
// reset: a sweep over 2^max(ADDR-byte bits, INDEX_BITS) entries zeroes store and line status,
//   no request taken meanwhile; top of dmwbc_ctrl and dmwbc_datapath, uses dmwbc_pkg, dmwbc_ifs
`default_nettype none

module direct_mapped_write_back_cache_core
    import dmwbc_pkg::*;
#(
    parameter int unsigned INDEX_BITS       = DEF_INDEX_BITS,
    parameter int unsigned WORD_SELECT_BITS = DEF_WORD_SELECT_BITS,
    parameter int unsigned LINE_OFFSET_BITS = DEF_LINE_OFFSET_BITS,
    parameter int unsigned ADDR_BITS        = DEF_ADDR_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dmwbc_req_if.sink  i_req,
    dmwbc_rsp_if.source o_rsp
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    dmwbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    dmwbc_datapath #(
        .INDEX_BITS       (INDEX_BITS),
        .WORD_SELECT_BITS (WORD_SELECT_BITS),
        .LINE_OFFSET_BITS (LINE_OFFSET_BITS),
        .ADDR_BITS        (ADDR_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_operation       (i_req.operation),
        .i_address         (i_req.address),
        .i_write_data      (i_req.write_data),
        .o_valid           (o_rsp.valid),
        .i_ready           (o_rsp.ready),
        .o_was_hit         (o_rsp.was_hit),
        .o_wrote_back      (o_rsp.wrote_back),
        .o_read_data       (o_rsp.read_data),
        .o_hit_count       (o_rsp.hit_count),
        .o_miss_count      (o_rsp.miss_count),
        .o_writeback_count (o_rsp.writeback_count)
    );

endmodule

`default_nettype wire

@@ design/dmwbc_checker.sv @@
// port-level checks for the cache core, bound to direct_mapped_write_back_cache_core
// depends on the core's request and result interfaces
`default_nettype none

module dmwbc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_req_valid,
    input wire logic i_req_ready,
    input wire logic i_rsp_valid,
    input wire logic i_rsp_ready,
    input wire logic i_was_hit,
    input wire logic i_wrote_back
);

    // no request taken in the cycle after reset, the clear sweep runs first
    a_no_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready)
        else $error("request ready right after reset");

    // one request in flight at a time
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("second request taken back to back");

    // a hit never evicts a line
    a_hit_no_writeback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_was_hit && i_wrote_back))
        else $error("hit reported with write-back");

    // result held until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("result dropped before taken");

endmodule

bind direct_mapped_write_back_cache_core dmwbc_checker u_dmwbc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_was_hit    (o_rsp.was_hit),
    .i_wrote_back (o_rsp.wrote_back)
);

`default_nettype wire
